// ===== rtl/mmn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmn_pkg
// shared constants, codes and controller/datapath interface types for the
// min/max byte normalizer
// ----------------------------------------------------------------------------
package mmn_pkg;

  // sample and channel sizing
  localparam int SAMPLE_BITS    = 32;
  localparam int MAX_CHANNELS   = 4;
  localparam int CFG_BITS       = 3;
  localparam int CNT_BITS       = CFG_BITS + 1;
  localparam int POS_BITS       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CFG_INDEX_BITS = 1;

  // divider sizing: quotient is one byte, remainder holds 255 * difference
  localparam int PIXEL_BITS     = 8;
  localparam int QUOT_BITS      = PIXEL_BITS;
  localparam int STEP_BITS      = $clog2(QUOT_BITS);
  localparam int DIFF_BITS      = SAMPLE_BITS + 1;
  localparam int REM_BITS       = DIFF_BITS + PIXEL_BITS;
  localparam int USER_OUT_BITS  = 3;

  localparam logic [PIXEL_BITS-1:0] FULL_SCALE    = PIXEL_BITS'(255);
  localparam logic [PIXEL_BITS-1:0] UNIFORM_PIXEL = PIXEL_BITS'(100);
  localparam logic [STEP_BITS-1:0]  LAST_STEP     = STEP_BITS'(QUOT_BITS - 1);

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic [CFG_BITS-1:0] NUM_CHANNELS_RESET   = CFG_BITS'(1);
  localparam logic [CFG_BITS-1:0] CHOSEN_CHANNEL_RESET = CFG_BITS'(0);
  localparam logic [CFG_BITS-1:0] CHOSEN_ALL           = CFG_BITS'(0);

  // request kind on the input tuser
  localparam logic MODE_SCAN      = 1'b0;
  localparam logic MODE_NORMALIZE = 1'b1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_NUM_CHANNELS   = 1'b0,
    REG_CHOSEN_CHANNEL = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept_scan;
    logic accept_norm;
    logic scale;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_valid;
  } stat_t;

endpackage

// ===== rtl/mmn_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmn_ctrl
// sequencer for the normalizer: accepts requests, steps the divider and
// hands results to the output register
// ----------------------------------------------------------------------------
module mmn_ctrl import mmn_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  input  logic  s_mode,
  input  stat_t stat,
  input  logic  m_tready,
  output cmd_t  cmd
);

  state_t                 state;
  state_t                 state_next;
  logic [STEP_BITS-1:0]   step;
  logic [STEP_BITS-1:0]   step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_mode == MODE_NORMALIZE) begin
            cmd.accept_norm = 1'b1;
            state_next      = ST_SCALE;
          end else begin
            cmd.accept_scan = 1'b1;
          end
        end
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        step_next  = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + STEP_BITS'(1);
        if (step == LAST_STEP) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        // output register free or draining this cycle
        if (!stat.out_valid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_div_to_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && step == LAST_STEP) |=> (state == ST_OUT))
    else $error("divider did not finish after the last quotient bit");

  a_norm_starts_scale: assert property (@(posedge clk) disable iff (rst)
    cmd.accept_norm |=> (state == ST_SCALE && !s_tready))
    else $error("normalize request did not start the scale step");

endmodule

// ===== rtl/mmn_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmn_datapath
// configuration, running min/max, channel tracking, restoring divider and
// output register of the normalizer
// ----------------------------------------------------------------------------
module mmn_datapath import mmn_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  cmd_t                          cmd,
  output stat_t                         stat,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_BITS-1:0]           cfg_data,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          last,
  input  logic                          m_tready,
  output logic                          out_valid,
  output logic [PIXEL_BITS-1:0]         pixel,
  output logic                          selected,
  output logic                          end_of_pass,
  output logic                          uniform,
  output logic                          config_error
);

  logic [CFG_BITS-1:0]           num_channels;
  logic [CFG_BITS-1:0]           chosen_channel;
  logic signed [SAMPLE_BITS-1:0] running_min;
  logic signed [SAMPLE_BITS-1:0] running_max;
  logic [POS_BITS-1:0]           channel_position;

  logic [CNT_BITS-1:0]           eff_channels;
  logic [CNT_BITS-1:0]           pos_inc;
  logic [POS_BITS-1:0]           pos_next;
  logic                          cfg_err;
  logic                          sel;
  logic signed [DIFF_BITS-1:0]   d_in;
  logic signed [DIFF_BITS-1:0]   r_in;

  // request held during the divide
  logic signed [DIFF_BITS-1:0]   d;
  logic signed [DIFF_BITS-1:0]   r;
  logic                          req_uniform;
  logic                          req_err;
  logic                          req_sel;
  logic                          req_last;
  logic [REM_BITS-1:0]           rem;
  logic [REM_BITS-1:0]           den;
  logic [QUOT_BITS-1:0]          quot;
  logic [PIXEL_BITS-1:0]         pixel_next;

  always_comb begin
    if (num_channels == '0) begin
      eff_channels = CNT_BITS'(1);
    end else if (CNT_BITS'(num_channels) > CNT_BITS'(MAX_CHANNELS)) begin
      eff_channels = CNT_BITS'(MAX_CHANNELS);
    end else begin
      eff_channels = CNT_BITS'(num_channels);
    end
  end

  assign cfg_err = CNT_BITS'(chosen_channel) > eff_channels;
  assign pos_inc = CNT_BITS'(channel_position) + CNT_BITS'(1);
  assign sel     = !cfg_err &&
                   (chosen_channel == CHOSEN_ALL || pos_inc == CNT_BITS'(chosen_channel));

  always_comb begin
    if (last || pos_inc >= eff_channels) begin
      pos_next = '0;
    end else begin
      pos_next = POS_BITS'(pos_inc);
    end
  end

  assign d_in = {sample[SAMPLE_BITS-1], sample} - {running_min[SAMPLE_BITS-1], running_min};
  assign r_in = {running_max[SAMPLE_BITS-1], running_max} -
                {running_min[SAMPLE_BITS-1], running_min};

  // configuration and running statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      num_channels     <= NUM_CHANNELS_RESET;
      chosen_channel   <= CHOSEN_CHANNEL_RESET;
      running_min      <= SAMPLE_MAX;
      running_max      <= SAMPLE_MIN;
      channel_position <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_NUM_CHANNELS:   num_channels   <= cfg_data;
          REG_CHOSEN_CHANNEL: chosen_channel <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.accept_scan || cmd.accept_norm) begin
        channel_position <= pos_next;
      end
      if (cmd.accept_scan && sel) begin
        if (sample < running_min) begin
          running_min <= sample;
        end
        if (sample > running_max) begin
          running_max <= sample;
        end
      end
      if (cmd.accept_norm && last) begin
        running_min <= SAMPLE_MAX;
        running_max <= SAMPLE_MIN;
      end
    end
  end

  // request capture and restoring divider
  always_ff @(posedge clk) begin
    if (cmd.accept_norm) begin
      d           <= d_in;
      r           <= r_in;
      req_uniform <= running_max <= running_min;
      req_err     <= cfg_err;
      req_sel     <= sel;
      req_last    <= last;
    end
    if (cmd.scale) begin
      rem  <= {d, {PIXEL_BITS{1'b0}}} - {{PIXEL_BITS{1'b0}}, d};
      den  <= {1'b0, r, {(QUOT_BITS-1){1'b0}}};
      quot <= '0;
    end
    if (cmd.div_step) begin
      if (rem >= den) begin
        rem  <= rem - den;
        quot <= {quot[QUOT_BITS-2:0], 1'b1};
      end else begin
        quot <= {quot[QUOT_BITS-2:0], 1'b0};
      end
      den <= den >> 1;
    end
  end

  always_comb begin
    if (req_err) begin
      pixel_next = '0;
    end else if (req_uniform) begin
      pixel_next = UNIFORM_PIXEL;
    end else if (d[DIFF_BITS-1] || d == '0) begin
      pixel_next = '0;
    end else if (d >= r) begin
      pixel_next = FULL_SCALE;
    end else begin
      pixel_next = quot;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pixel        <= pixel_next;
      selected     <= req_sel;
      end_of_pass  <= req_last;
      uniform      <= req_uniform && !req_err;
      config_error <= req_err;
    end
  end

  assign stat.out_valid = out_valid;

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept_norm && last) |=> (running_min == SAMPLE_MAX && running_max == SAMPLE_MIN))
    else $error("min/max not restarted after end of normalize pass");

  a_uniform_pixel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && uniform) |-> (pixel == UNIFORM_PIXEL && !config_error))
    else $error("uniform result without uniform pixel");

  a_error_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && config_error) |-> (pixel == '0 && !selected))
    else $error("config error result carries data");

endmodule

// ===== rtl/min_max_normalize_to_byte.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_max_normalize_to_byte
// two-pass min/max normalizer of interleaved q16.16 samples to bytes
// ----------------------------------------------------------------------------
// A frame is streamed twice. Scan requests (tuser 0) fold the selected
// samples into a running minimum and maximum, produce no output and leave
// the block ready. Normalize requests (tuser 1) each produce one byte,
// floor(255*(x-min)/(max-min)) clamped to 0..255, from an 8-step restoring
// divider: accept, scale, eight quotient bits and output load, which waits
// while the sink still holds the output register. The output register
// lets a new request enter while the previous result waits. tlast on a
// normalize request ends the frame and restarts min/max; tlast on any
// request restarts the channel count. chosen_channel 0 selects every
// channel, a value above num_channels (0 read as 1, capped at MAX_CHANNELS)
// flags config_error with byte 0, and an empty or flat range gives byte 100
// with the uniform flag. Configuration must be written only while no
// request is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module min_max_normalize_to_byte import mmn_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  // config write port
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_BITS-1:0]           cfg_data,
  // sample requests
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic signed [SAMPLE_BITS-1:0] s_tdata,   // [31:0] sample
  input  logic                          s_tlast,   // last sample of the pass
  input  logic                          s_tuser,   // [0] mode
  // byte results
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [PIXEL_BITS-1:0]         m_tdata,   // [7:0] pixel
  output logic                          m_tlast,   // end_of_pass
  output logic [USER_OUT_BITS-1:0]      m_tuser    // [0] selected [1] uniform [2] config_error
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer: one state per phase of a normalize request
  mmn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_mode   (s_tuser),
    .stat     (stat),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // statistics, divider and output register
  mmn_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample       (s_tdata),
    .last         (s_tlast),
    .m_tready     (m_tready),
    .out_valid    (m_tvalid),
    .pixel        (m_tdata),
    .selected     (m_tuser[0]),
    .end_of_pass  (m_tlast),
    .uniform      (m_tuser[1]),
    .config_error (m_tuser[2])
  );

endmodule
